FILE: hw/rtl/gr4_pkg.sv
// ============================================================================
// gr4_pkg: shared types and constants of the glyph RLE decoder
// Holds the queue entry, the configuration bundle and the codes used by the
// front and back parts of the decoder.
// ============================================================================
package gr4_pkg;

    // Field widths fixed by the byte format and the bitmap layout.
    localparam int RUN_W   = 4;
    localparam int GRAY_W  = 4;
    localparam int SIDE_W  = 8;
    localparam int BUF_W   = 16;
    localparam int ADDR_W  = 15;
    localparam int TOTAL_W = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 2'd2;

    // Run byte layout: count in the high nibble, gray in the low nibble.
    localparam logic [7:0] COUNT_MASK = 8'hF0;
    localparam logic [7:0] GRAY_MASK  = 8'h0F;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Operation codes decided by the front part.
    typedef enum logic {
        OP_RUN     = 1'b0,
        OP_END_ROW = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [RUN_W-1:0]   count;
        logic [GRAY_W-1:0]  gray;
        logic               last;
    } q_entry_t;

    typedef struct packed {
        logic [SIDE_W-1:0] glyph_width;
        logic [SIDE_W-1:0] glyph_height;
        logic [BUF_W-1:0]  buffer_bytes;
    } cfg_t;

endpackage

FILE: hw/rtl/gr4_channels.sv
// ============================================================================
// gr4_channels: valid/ready channels of the glyph RLE decoder
// One interface carries run bytes in, the other carries pixel writes out.
// ============================================================================
interface gr4_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rle_byte;
    logic       last_byte;

    modport source (output valid, output rle_byte, output last_byte, input ready);
    modport sink   (input valid, input rle_byte, input last_byte, output ready);
endinterface

interface gr4_out_if;
    logic                          valid;
    logic                          ready;
    logic [gr4_pkg::ADDR_W-1:0]    byte_addr;
    logic                          high_nibble;
    logic [gr4_pkg::GRAY_W-1:0]    gray;
    logic [gr4_pkg::TOTAL_W-1:0]   pixels_so_far;
    logic                          last_of_run;

    modport source (output valid, output byte_addr, output high_nibble, output gray,
                    output pixels_so_far, output last_of_run, input ready);
    modport sink   (input valid, input byte_addr, input high_nibble, input gray,
                    input pixels_so_far, input last_of_run, output ready);
endinterface

FILE: hw/rtl/gr4_front.sv
// ============================================================================
// gr4_front: run byte intake and command queue
// Accepts run bytes, splits each into a run or an end-of-row command and
// holds the commands in a short queue for the back part.
// ============================================================================
module gr4_front (
    input  logic               clk,
    input  logic               rst_n,
    gr4_in_if.sink             rle_in,
    output logic               q_valid,
    output gr4_pkg::q_entry_t  q_entry,
    input  logic               q_pop
);

    gr4_pkg::q_entry_t                 mem_reg [gr4_pkg::QUEUE_DEPTH];
    logic [gr4_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [gr4_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [gr4_pkg::QCNT_W-1:0]        cnt_reg;
    logic [gr4_pkg::QCNT_W-1:0]        cnt_next;
    gr4_pkg::q_entry_t                 new_entry;
    logic                              push;
    logic [7:0]                        count_bits;

    // Classify the incoming beat.
    assign count_bits      = rle_in.rle_byte & gr4_pkg::COUNT_MASK;
    always_comb
    begin
        new_entry.count = count_bits[7:4];
        new_entry.gray  = rle_in.rle_byte[3:0] & gr4_pkg::GRAY_MASK[3:0];
        new_entry.last  = rle_in.last_byte;
        new_entry.op    = (count_bits == 8'h00) ? gr4_pkg::OP_END_ROW : gr4_pkg::OP_RUN;
    end

    assign rle_in.ready = (cnt_reg != gr4_pkg::QCNT_W'(gr4_pkg::QUEUE_DEPTH));
    assign push         = rle_in.valid && rle_in.ready;
    assign q_valid      = (cnt_reg != '0);
    assign q_entry      = mem_reg[rd_ptr_reg];

    // Occupancy count.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("gr4_front: pop from an empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= gr4_pkg::QCNT_W'(gr4_pkg::QUEUE_DEPTH))
        else $error("gr4_front: queue count beyond depth");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("gr4_front: queue count missed a push");
`endif

endmodule

FILE: hw/rtl/gr4_back.sv
// ============================================================================
// gr4_back: run expansion and pixel write generation
// Takes commands from the queue, tracks row, column and base address, and
// expands each run into pixel writes through an output register.
// ============================================================================
module gr4_back #(
    parameter int MAX_GLYPH_SIDE = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gr4_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  gr4_pkg::q_entry_t  q_entry,
    output logic               q_pop,
    gr4_out_if.source          pix_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam logic [gr4_pkg::SIDE_W-1:0] SIDE_CAP = gr4_pkg::SIDE_W'(MAX_GLYPH_SIDE);

    logic                              state_reg, state_next;
    logic [gr4_pkg::SIDE_W-1:0]        row_reg, row_next;
    logic [gr4_pkg::SIDE_W-1:0]        col_reg, col_next;
    logic [gr4_pkg::ADDR_W-1:0]        base_reg, base_next;
    logic [gr4_pkg::TOTAL_W-1:0]       total_reg, total_next;
    logic [gr4_pkg::RUN_W-1:0]         cnt_reg, cnt_next;
    logic [gr4_pkg::GRAY_W-1:0]        gray_reg, gray_next;
    logic                              last_reg, last_next;

    logic                              out_valid_reg;
    logic [gr4_pkg::ADDR_W-1:0]        addr_reg;
    logic                              high_reg;
    logic [gr4_pkg::GRAY_W-1:0]        pgray_reg;
    logic [gr4_pkg::TOTAL_W-1:0]       ptotal_reg;
    logic                              lor_reg;

    logic [gr4_pkg::SIDE_W-1:0]        width;
    logic [gr4_pkg::SIDE_W-1:0]        height;
    logic [gr4_pkg::SIDE_W-1:0]        row_span;
    logic [gr4_pkg::SIDE_W:0]          width_sum;
    logic [gr4_pkg::BUF_W-1:0]         needed;
    logic                              active;
    logic                              slot_free;
    logic                              emit;
    logic                              done;
    logic [gr4_pkg::SIDE_W:0]          col_inc;

    // Effective glyph geometry and the buffer fit check.
    assign width     = (cfg.glyph_width  > SIDE_CAP) ? SIDE_CAP : cfg.glyph_width;
    assign height    = (cfg.glyph_height > SIDE_CAP) ? SIDE_CAP : cfg.glyph_height;
    assign width_sum = {1'b0, width} + 1'b1;
    assign row_span  = width_sum[gr4_pkg::SIDE_W:1];
    assign needed    = gr4_pkg::BUF_W'(row_span * height);
    assign active    = (needed <= cfg.buffer_bytes) && (row_reg < height);
    assign slot_free = !out_valid_reg || pix_out.ready;
    assign col_inc   = {1'b0, col_reg} + 1'b1;

    // Sequencer: one command per visit to idle, one pixel per cycle in a run while the output slot is free.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        base_next  = base_reg;
        total_next = total_reg;
        cnt_next   = cnt_reg;
        gray_next  = gray_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.op == gr4_pkg::OP_END_ROW)
                    begin
                        if (active)
                        begin
                            row_next  = row_reg + 1'b1;
                            col_next  = '0;
                            base_next = base_reg + gr4_pkg::ADDR_W'(row_span);
                        end
                        if (q_entry.last)
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            base_next  = '0;
                            total_next = '0;
                        end
                    end
                    else if (active)
                    begin
                        state_next = ST_RUN;
                        cnt_next   = q_entry.count;
                        gray_next  = q_entry.gray;
                        last_next  = q_entry.last;
                    end
                    else if (q_entry.last)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        base_next  = '0;
                        total_next = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (col_reg >= width)
                begin
                    done = 1'b1;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    done       = (cnt_reg == gr4_pkg::RUN_W'(1))
                                 || (col_inc == {1'b0, width});
                    total_next = total_reg + 1'b1;
                    col_next   = col_inc[gr4_pkg::SIDE_W-1:0];
                    cnt_next   = cnt_reg - 1'b1;
                end
                if (done)
                begin
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        base_next  = '0;
                        total_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
            total_reg <= total_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Run payload and the output register.
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        gray_reg <= gray_next;
        last_reg <= last_next;
        if (emit)
        begin
            addr_reg   <= base_reg + gr4_pkg::ADDR_W'(col_reg[gr4_pkg::SIDE_W-1:1]);
            high_reg   <= ~col_reg[0];
            pgray_reg  <= gray_reg;
            ptotal_reg <= total_reg + 1'b1;
            lor_reg    <= done;
        end
    end

    assign pix_out.valid         = out_valid_reg;
    assign pix_out.byte_addr     = addr_reg;
    assign pix_out.high_nibble   = high_reg;
    assign pix_out.gray          = pgray_reg;
    assign pix_out.pixels_so_far = ptotal_reg;
    assign pix_out.last_of_run   = lor_reg;

`ifndef SYNTH
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg != '0))
        else $error("gr4_back: run state with no pixels left");
    a_col_inside: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (col_reg < width))
        else $error("gr4_back: pixel emitted past glyph width");
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !done) |=> (state_reg == ST_RUN))
        else $error("gr4_back: run left before its last pixel");
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !(done && last_reg)) |=> (total_reg == $past(total_reg) + 1'b1))
        else $error("gr4_back: pixel count did not advance");
    a_no_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !q_pop)
        else $error("gr4_back: queue popped during a run");
`endif

endmodule

FILE: hw/rtl/glyph_rle_to_4bpp_decoder.sv
// ============================================================================
// glyph_rle_to_4bpp_decoder: glyph RLE to 4bpp packed bitmap writer
// Top level: configuration registers, run byte intake and pixel expansion.
// ============================================================================
// Usage:
// Run bytes enter on rle_in, one per beat: the high nibble is a run count,
// the low nibble a gray level, and a count of zero closes the current row.
// last_byte marks the final beat of a glyph; after it the row, column, base
// address and pixel count return to zero. Each run pixel inside the glyph
// leaves on pix_out as one beat with its byte address, nibble select, gray,
// running pixel count and a flag on the last pixel of its run byte.
// Geometry and buffer size are written on the cfg_we/cfg_index/cfg_wdata
// port; the user must write them only while the block is idle, as the
// block itself does not enforce it. An accepted run byte passes through
// the command queue, the run state of the expansion sequencer and the
// output register before its first pixel is valid; a two-entry command
// queue lets intake run ahead of expansion.
// When pix_out stalls, the output register holds its beat and expansion
// waits; intake stops once the queue is full. Reset empties the queue and
// the output register and restores the register defaults.
module glyph_rle_to_4bpp_decoder #(
    parameter int MAX_GLYPH_SIDE = 255
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gr4_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gr4_pkg::BUF_W-1:0]         cfg_wdata,
    gr4_in_if.sink                            rle_in,
    gr4_out_if.source                         pix_out
);

    gr4_pkg::cfg_t      cfg_reg;
    logic               q_valid;
    gr4_pkg::q_entry_t  q_entry;
    logic               q_pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width  <= gr4_pkg::SIDE_W'(1);
            cfg_reg.glyph_height <= gr4_pkg::SIDE_W'(1);
            cfg_reg.buffer_bytes <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gr4_pkg::CFG_GLYPH_WIDTH:
                begin
                    cfg_reg.glyph_width <= cfg_wdata[gr4_pkg::SIDE_W-1:0];
                end
                gr4_pkg::CFG_GLYPH_HEIGHT:
                begin
                    cfg_reg.glyph_height <= cfg_wdata[gr4_pkg::SIDE_W-1:0];
                end
                gr4_pkg::CFG_BUFFER_BYTES:
                begin
                    cfg_reg.buffer_bytes <= cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Intake and command queue.
    gr4_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rle_in  (rle_in),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    // Run expansion.
    gr4_back #(
        .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .pix_out (pix_out)
    );

endmodule
